// File: hdl/alpe_pkg.sv
// ----------------------------------------------------------------------------
// alpe_pkg
// Shared types and constants of the addressable LED pulse encoder.
// ----------------------------------------------------------------------------
package alpe_pkg;

    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned WORD_W      = 3 * COLOR_W;
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned SEGS        = 2 * WORD_W + 1;
    localparam int unsigned SEG_W       = $clog2(SEGS);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SEGS - 1);

    localparam logic [TICK_W-1:0] ONE_HIGH_RESET   = TICK_W'(70);
    localparam logic [TICK_W-1:0] ONE_LOW_RESET    = TICK_W'(5);
    localparam logic [TICK_W-1:0] ZERO_HIGH_RESET  = TICK_W'(5);
    localparam logic [TICK_W-1:0] ZERO_LOW_RESET   = TICK_W'(70);
    localparam logic [TICK_W-1:0] LATCH_LOW_RESET  = TICK_W'(4300);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_HIGH  = 3'd0,
        REG_ONE_LOW   = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ZERO_LOW  = 3'd3,
        REG_LATCH_LOW = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] latch_low;
    } timing_t;

    typedef struct packed {
        logic              strip;
        logic [WORD_W-1:0] word;
    } pixel_t;

endpackage

// File: hdl/alpe_ifs.sv
// ----------------------------------------------------------------------------
// alpe_ifs
// Handshake channels: pixel requests in, line segment requests out.
// ----------------------------------------------------------------------------
interface alpe_pixel_if
    import alpe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               strip;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output strip, output green, output red, output blue,
                    input ready);
    modport sink   (input valid, input strip, input green, input red, input blue,
                    output ready);
endinterface

interface alpe_segment_if
    import alpe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              line;
    logic              level;
    logic [TICK_W-1:0] duration;
    logic              last;

    modport source (output valid, output line, output level, output duration, output last,
                    input ready);
    modport sink   (input valid, input line, input level, input duration, input last,
                     output ready);
endinterface

// File: hdl/alpe_front.sv
// ----------------------------------------------------------------------------
// alpe_front
// Accepts pixel requests, packs the color bytes in send order and holds them
// in a two-entry queue for the segment sequencer.
// ----------------------------------------------------------------------------
module alpe_front
    import alpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    alpe_pixel_if.sink   pixel,
    output logic         q_valid,
    input  logic         q_ready,
    output pixel_t       q_pixel
);

    pixel_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;
    pixel_t              packed_pixel;

    assign pixel.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push        = pixel.valid && pixel.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_valid && q_ready;
    assign q_pixel     = entry_reg[rd_ptr_reg];

    assign packed_pixel.strip = pixel.strip;
    assign packed_pixel.word  = {pixel.green, pixel.red, pixel.blue};

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= packed_pixel;
        end
    end

endmodule

// File: hdl/alpe_back.sv
// ----------------------------------------------------------------------------
// alpe_back
// Segment sequencer: walks one pixel through its latch segment and the
// high and low segments of its 24 bits, one segment per cycle while the
// segment sink is ready, into an output register.
// ----------------------------------------------------------------------------
module alpe_back
    import alpe_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  timing_t        timing,
    input  logic           q_valid,
    output logic           q_ready,
    input  pixel_t         q_pixel,
    alpe_segment_if.source segment
);

    logic              act_valid_reg;
    logic              act_valid_next;
    pixel_t            act_reg;
    pixel_t            act_next;
    logic [SEG_W-1:0]  seg_reg;
    logic [SEG_W-1:0]  seg_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              line_reg;
    logic              level_reg;
    logic [TICK_W-1:0] duration_reg;
    logic              last_reg;
    logic              advance;
    logic              produce;
    logic              seg_latch;
    logic              seg_high;
    logic              seg_last;
    logic              cur_bit;
    logic [TICK_W-1:0] raw_ticks;
    logic [TICK_W-1:0] seg_ticks;

    assign advance   = !out_valid_reg || segment.ready;
    assign produce   = advance && act_valid_reg;
    assign seg_latch = (seg_reg == '0);
    assign seg_high  = seg_reg[0];
    assign seg_last  = (seg_reg == LAST_SEG);
    assign cur_bit   = act_reg.word[WORD_W-1];
    assign q_ready   = !act_valid_reg || (produce && seg_last);

    always_comb
    begin
        priority if (seg_latch)
        begin
            raw_ticks = timing.latch_low;
        end
        else if (seg_high)
        begin
            raw_ticks = cur_bit ? timing.one_high : timing.zero_high;
        end
        else
        begin
            raw_ticks = cur_bit ? timing.one_low : timing.zero_low;
        end
        seg_ticks = (raw_ticks == '0) ? TICK_W'(1) : raw_ticks;
    end

    always_comb
    begin
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        seg_next       = seg_reg;
        out_valid_next = advance ? act_valid_reg : out_valid_reg;
        if (produce)
        begin
            if (seg_last)
            begin
                act_valid_next = 1'b0;
                seg_next       = '0;
            end
            else
            begin
                seg_next = seg_reg + 1'b1;
                if (!seg_latch && !seg_high)
                begin
                    act_next.word = {act_reg.word[WORD_W-2:0], 1'b0};
                end
            end
        end
        if (q_valid && q_ready)
        begin
            act_valid_next = 1'b1;
            act_next       = q_pixel;
            seg_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        if (produce)
        begin
            line_reg     <= act_reg.strip;
            level_reg    <= seg_high;
            duration_reg <= seg_ticks;
            last_reg     <= seg_last;
        end
    end

    assign segment.valid    = out_valid_reg;
    assign segment.line     = line_reg;
    assign segment.level    = level_reg;
    assign segment.duration = duration_reg;
    assign segment.last     = last_reg;

`ifndef NO_ASSERTIONS
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg <= LAST_SEG)
        else $error("segment counter out of range");

    a_last_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        (segment.valid && segment.last) |-> !segment.level)
        else $error("final segment is not a low segment");

    a_pixel_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(act_valid_reg) |-> $past(seg_reg) == LAST_SEG)
        else $error("pixel dropped before its final segment");

    a_nonzero_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        segment.valid |-> segment.duration != '0)
        else $error("segment with zero duration");
`endif

endmodule

// File: hdl/addressable_led_pulse_encoder.sv
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder
// Turns pixel colors into timed high and low line segments for serial LEDs.
//
//   channel   direction  payload                          handshake
//   pixel     in         strip, green, red, blue          valid / ready
//   segment   out        line, level, duration, last      valid / ready
//   cfg       in         cfg_index, cfg_data              cfg_we, no wait
//
// Each pixel request yields 49 segment requests, one per cycle when the sink
// keeps ready high. The sequencer takes the next queued pixel while it hands
// out the last segment of the current one; the front queue holds two more.
// Reset loads the default timing and empties the queue and output register.
// A stalled segment sink holds the sequencer; the front keeps taking pixels
// until its two-entry queue is full.
// ----------------------------------------------------------------------------
module addressable_led_pulse_encoder
    import alpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    alpe_pixel_if.sink           pixel,
    alpe_segment_if.source       segment,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    timing_t timing_reg;
    timing_t timing_next;
    logic    q_valid;
    logic    q_ready;
    pixel_t  q_pixel;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ONE_HIGH:  timing_next.one_high  = cfg_data;
                REG_ONE_LOW:   timing_next.one_low   = cfg_data;
                REG_ZERO_HIGH: timing_next.zero_high = cfg_data;
                REG_ZERO_LOW:  timing_next.zero_low  = cfg_data;
                REG_LATCH_LOW: timing_next.latch_low = cfg_data;
                default:       timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.one_high  <= ONE_HIGH_RESET;
            timing_reg.one_low   <= ONE_LOW_RESET;
            timing_reg.zero_high <= ZERO_HIGH_RESET;
            timing_reg.zero_low  <= ZERO_LOW_RESET;
            timing_reg.latch_low <= LATCH_LOW_RESET;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    alpe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_pixel (q_pixel)
    );

    alpe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .timing  (timing_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_pixel (q_pixel),
        .segment (segment)
    );

endmodule
